// ----- hdl/xss_pkg.sv -----
// xss_pkg: shared constants and helpers for the xorshift64* random source.
// Used by xss_mul, xorshift_star_random_source_unit and its testbench; no dependencies.
package xss_pkg;

  localparam int unsigned STATE_W = 64;
  localparam int unsigned WORD_W  = 32;

  localparam logic [STATE_W-1:0] XS_MULT = 64'h2545_F491_4F6C_DD1D;
  localparam int unsigned        SHIFT_A = 12;
  localparam int unsigned        SHIFT_B = 25;
  localparam int unsigned        SHIFT_C = 27;

  localparam logic [WORD_W-1:0]  WORD_MAX = {WORD_W{1'b1}};

  // Request kinds
  localparam logic [1:0] OP_FRACTION = 2'd0;
  localparam logic [1:0] OP_COIN     = 2'd1;
  localparam logic [1:0] OP_RANGE    = 2'd2;
  localparam logic [1:0] OP_NONE     = 2'd3;

  typedef logic [WORD_W-1:0]   word_t;
  typedef logic [2*WORD_W-1:0] prod_t;

  // One xorshift step on the 64-bit state
  function automatic logic [STATE_W-1:0] xorshift(input logic [STATE_W-1:0] s);
    logic [STATE_W-1:0] x;
    x = s;
    x = x ^ (x >> SHIFT_A);
    x = x ^ (x << SHIFT_B);
    x = x ^ (x >> SHIFT_C);
    return x;
  endfunction

endpackage

// ----- hdl/xorshift_star_random_source_unit.sv -----
// xorshift_star_random_source_unit: xorshift64* generator with a small sequencer.
// Depends on xss_pkg and xss_mul (the one shared multiplier).
//
// Each fraction, coin or unequal-bound range request advances the 64-bit state
// by one xorshift step and scrambles it through a 64-bit multiply that is built
// from three passes of one 32x32 multiplier; a range request uses that multiplier
// a fourth time to scale the fraction, then divides by 2^32-1 with one compare
// and increment. A fraction or coin request passes through states M0 to M3 and
// then FIN, a range request adds M4 and DV before FIN, a range with equal bounds
// goes straight to FIN and an op code of 3 is dropped; FIN waits for the output
// register to drain. The input side stalls while a request is in flight; the
// output register lets the next request start while a result still waits. A
// seed write loads the state at once, with zero replaced by one.
module xorshift_star_random_source_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic signed [31:0] range_low_i,
  input  logic signed [31:0] range_high_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] fraction_o,
  output logic        coin_o,
  output logic signed [31:0] range_value_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_M0   = 3'd1;
  localparam logic [2:0] ST_M1   = 3'd2;
  localparam logic [2:0] ST_M2   = 3'd3;
  localparam logic [2:0] ST_M3   = 3'd4;
  localparam logic [2:0] ST_M4   = 3'd5;
  localparam logic [2:0] ST_DV   = 3'd6;
  localparam logic [2:0] ST_FIN  = 3'd7;

  logic [2:0]  st_q, st_d;
  logic [63:0] gen_q, gen_d;
  logic        range_q, range_d;
  xss_pkg::word_t lo_q, lo_d;
  xss_pkg::word_t diff_q, diff_d;
  xss_pkg::word_t frac_q, frac_d;
  logic        coin_q, coin_d;
  xss_pkg::word_t res_q, res_d;

  logic        out_valid_q, out_valid_d;
  xss_pkg::word_t out_frac_q, out_frac_d;
  logic        out_coin_q, out_coin_d;
  xss_pkg::word_t out_range_q, out_range_d;

  xss_pkg::word_t mul_a, mul_b;
  xss_pkg::prod_t prod;

  logic           in_acc;
  logic           slot_free;
  logic           swap;
  xss_pkg::word_t b_lo, b_hi;
  xss_pkg::word_t u_sum;
  logic [32:0]    div_sum;

  xss_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign in_stall_o = (st_q != ST_IDLE);
  assign in_acc     = in_valid_i && (st_q == ST_IDLE);
  assign slot_free  = !out_valid_q || !out_stall_i;

  assign swap  = (range_high_i < range_low_i);
  assign b_lo  = swap ? range_high_i : range_low_i;
  assign b_hi  = swap ? range_low_i  : range_high_i;
  assign u_sum = frac_q + prod[31:0];
  // p = a*2^32 + b = a*(2^32-1) + (a+b), and a+b stays below 2*(2^32-1)
  assign div_sum = {1'b0, prod[63:32]} + {1'b0, prod[31:0]};

  // Multiplier operand select
  always_comb begin
    unique case (st_q)
      ST_M0: begin
        mul_a = gen_q[31:0];
        mul_b = xss_pkg::XS_MULT[31:0];
      end
      ST_M1: begin
        mul_a = gen_q[63:32];
        mul_b = xss_pkg::XS_MULT[31:0];
      end
      ST_M2: begin
        mul_a = gen_q[31:0];
        mul_b = xss_pkg::XS_MULT[63:32];
      end
      ST_M4: begin
        mul_a = frac_q;
        mul_b = diff_q;
      end
      default: begin
        mul_a = frac_q;
        mul_b = diff_q;
      end
    endcase
  end

  always_comb begin
    st_d    = st_q;
    gen_d   = gen_q;
    range_d = range_q;
    lo_d    = lo_q;
    diff_d  = diff_q;
    frac_d  = frac_q;
    coin_d  = coin_q;
    res_d   = res_q;

    out_valid_d = out_valid_q && out_stall_i;
    out_frac_d  = out_frac_q;
    out_coin_d  = out_coin_q;
    out_range_d = out_range_q;

    unique case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          range_d = (op_i == xss_pkg::OP_RANGE);
          lo_d    = '0;
          res_d   = '0;
          diff_d  = b_hi - b_lo;
          unique case (op_i)
            xss_pkg::OP_FRACTION, xss_pkg::OP_COIN: begin
              gen_d = xss_pkg::xorshift(gen_q);
              st_d  = ST_M0;
            end
            xss_pkg::OP_RANGE: begin
              lo_d = b_lo;
              if (range_high_i == range_low_i) begin
                // equal bounds: hold the state, return the bound
                frac_d = '0;
                coin_d = 1'b0;
                st_d   = ST_FIN;
              end else begin
                gen_d = xss_pkg::xorshift(gen_q);
                st_d  = ST_M0;
              end
            end
            xss_pkg::OP_NONE: st_d = ST_IDLE;
            default:          st_d = ST_IDLE;
          endcase
        end
      end
      ST_M0: st_d = ST_M1;
      ST_M1: begin
        frac_d = prod[63:32];
        st_d   = ST_M2;
      end
      ST_M2: begin
        frac_d = u_sum;
        st_d   = ST_M3;
      end
      ST_M3: begin
        frac_d = u_sum;
        coin_d = ~u_sum[31];
        st_d   = range_q ? ST_M4 : ST_FIN;
      end
      ST_M4: st_d = ST_DV;
      ST_DV: begin
        res_d = (div_sum >= {1'b0, xss_pkg::WORD_MAX}) ? prod[63:32] + 32'd1 : prod[63:32];
        st_d  = ST_FIN;
      end
      ST_FIN: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_frac_d  = frac_q;
          out_coin_d  = coin_q;
          out_range_d = lo_q + res_q;
          st_d        = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase

    if (cfg_we_i) begin
      gen_d = (cfg_wdata_i == 64'd0) ? 64'd1 : cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      gen_q       <= 64'd1;
      range_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      gen_q       <= gen_d;
      range_q     <= range_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q        <= lo_d;
    diff_q      <= diff_d;
    frac_q      <= frac_d;
    coin_q      <= coin_d;
    res_q       <= res_d;
    out_frac_q  <= out_frac_d;
    out_coin_q  <= out_coin_d;
    out_range_q <= out_range_d;
  end

  assign out_valid_o   = out_valid_q;
  assign fraction_o    = out_frac_q;
  assign coin_o        = out_coin_q;
  assign range_value_o = out_range_q;

endmodule

// ----- hdl/xss_mul.sv -----
// xss_mul: shared 32x32 unsigned multiplier with a registered product.
// Depends on xss_pkg for the word and product types.
module xss_mul (
  input  logic           clk_i,
  input  xss_pkg::word_t a_i,
  input  xss_pkg::word_t b_i,
  output xss_pkg::prod_t p_o
);

  xss_pkg::prod_t p_q;

  always_ff @(posedge clk_i) begin
    p_q <= xss_pkg::prod_t'(a_i) * xss_pkg::prod_t'(b_i);
  end

  assign p_o = p_q;

endmodule

// ----- dv/xorshift_star_random_source_unit_test.sv -----
// Self-checking testbench for xorshift_star_random_source_unit: fraction, coin and
// range requests under several seeds and idle patterns, checked by a built-in predictor.
// Depends on xss_pkg and the unit's RTL; reads no files.
module xorshift_star_random_source_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 300_000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 75;

  localparam logic [31:0] Q_MIN = 32'h8000_0000;
  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_ONE = 32'h0001_0000;

  typedef struct packed {
    logic [31:0] frac;
    logic        coin;
    logic [31:0] val;
  } draw_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] lo;
    logic [31:0] hi;
    logic        known;
    draw_t       typed;
  } stim_row_t;

  // Rows with known set carry a result that needs no arithmetic: equal bounds.
  localparam int NUM_ROWS = 20;
  localparam stim_row_t DIRECTED_ROWS [0:NUM_ROWS-1] = '{
    '{xss_pkg::OP_FRACTION, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
    '{xss_pkg::OP_COIN, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
    '{xss_pkg::OP_FRACTION, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
    '{xss_pkg::OP_RANGE, Q_MIN, Q_MAX, 1'b0, '0},
    '{xss_pkg::OP_RANGE, Q_MAX, Q_MIN, 1'b0, '0},
    '{xss_pkg::OP_RANGE, Q_MIN, Q_MIN, 1'b1, '{32'd0, 1'b0, Q_MIN}},
    '{xss_pkg::OP_RANGE, Q_MAX, Q_MAX, 1'b1, '{32'd0, 1'b0, Q_MAX}},
    '{xss_pkg::OP_RANGE, 32'h0000_0000, 32'h0000_0000, 1'b1, '{32'd0, 1'b0, 32'h0000_0000}},
    '{xss_pkg::OP_RANGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'd0, 1'b0, 32'hFFFF_FFFF}},
    '{xss_pkg::OP_NONE, 32'h1234_5678, 32'h9ABC_DEF0, 1'b0, '0},
    '{xss_pkg::OP_RANGE, 32'h0000_0000, 32'h0000_0001, 1'b0, '0},
    '{xss_pkg::OP_RANGE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, '0},
    '{xss_pkg::OP_RANGE, Q_ONE, 32'h0002_0000, 1'b0, '0},
    '{xss_pkg::OP_NONE, Q_MIN, Q_MAX, 1'b0, '0},
    '{xss_pkg::OP_COIN, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0},
    '{xss_pkg::OP_RANGE, Q_MAX, 32'h7FFF_FFFE, 1'b0, '0},
    '{xss_pkg::OP_RANGE, 32'h8000_0001, Q_MIN, 1'b0, '0},
    '{xss_pkg::OP_FRACTION, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0},
    '{xss_pkg::OP_NONE, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
    '{xss_pkg::OP_RANGE, 32'h7FFF_0000, 32'h7FFF_0000, 1'b1, '{32'd0, 1'b0, 32'h7FFF_0000}}
  };

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               cfg_we_i     = 1'b0;
  logic [63:0]        cfg_wdata_i  = '0;
  logic               in_valid_i   = 1'b0;
  logic               in_stall_o;
  logic [1:0]         op_i         = xss_pkg::OP_FRACTION;
  logic signed [31:0] range_low_i  = '0;
  logic signed [31:0] range_high_i = '0;
  logic               out_valid_o;
  logic               out_stall_i  = 1'b0;
  logic [31:0]        fraction_o;
  logic               coin_o;
  logic signed [31:0] range_value_o;

  xorshift_star_random_source_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .range_low_i   (range_low_i),
    .range_high_i  (range_high_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .fraction_o    (fraction_o),
    .coin_o        (coin_o),
    .range_value_o (range_value_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  logic [63:0] gen_state;
  draw_t       pending_draws[$];
  int          sender_idle_pct = 0;
  int          stall_pct       = 0;
  int          failures        = 0;
  int          requests_sent   = 0;
  int          draws_checked   = 0;
  int          seeds_loaded    = 0;
  int          cycle_count     = 0;

  function automatic bit roll(input int pct);
    return $urandom_range(99) < pct;
  endfunction

  // Predict a draw, advancing the generator unless the request is dropped or the bounds are equal.
  task automatic predict_draw(input logic [1:0] op, input logic [31:0] lo_in,
                              input logic [31:0] hi_in, output bit produces,
                              output draw_t d);
    logic [63:0]        x;
    logic [63:0]        prod;
    logic [63:0]        scaled;
    logic [63:0]        quot;
    logic [31:0]        u;
    logic signed [32:0] lo_x;
    logic signed [32:0] hi_x;
    logic signed [32:0] tmp;
    logic [32:0]        span;
    produces = 1'b1;
    d = '0;
    lo_x = {lo_in[31], lo_in};
    hi_x = {hi_in[31], hi_in};
    if (op == xss_pkg::OP_NONE) begin
      produces = 1'b0;
      return;
    end
    if (op == xss_pkg::OP_RANGE) begin
      if (hi_x == lo_x) begin
        d.val = lo_in;
        return;
      end
      if (hi_x < lo_x) begin
        tmp = lo_x;
        lo_x = hi_x;
        hi_x = tmp;
      end
    end
    x = gen_state;
    x = x ^ (x >> xss_pkg::SHIFT_A);
    x = x ^ (x << xss_pkg::SHIFT_B);
    x = x ^ (x >> xss_pkg::SHIFT_C);
    gen_state = x;
    prod = x * xss_pkg::XS_MULT;
    u = prod[63:32];
    d.frac = u;
    d.coin = ~u[31];
    if (op == xss_pkg::OP_RANGE) begin
      span = hi_x - lo_x;
      scaled = {32'd0, u} * {32'd0, span[31:0]};
      quot = scaled / {32'd0, xss_pkg::WORD_MAX};
      d.val = lo_x[31:0] + quot[31:0];
    end
  endtask

  task automatic report_failure(input string what, input draw_t want, input draw_t got);
    failures++;
    if (failures <= 10)
      $display("[%0d] %s: expected frac=%h coin=%b val=%h, got frac=%h coin=%b val=%h",
               cycle_count, what, want.frac, want.coin, want.val,
               got.frac, got.coin, got.val);
  endtask

  task automatic send_request(input logic [1:0] op, input logic [31:0] lo,
                              input logic [31:0] hi, input logic known,
                              input draw_t typed);
    bit    produces;
    draw_t d;
    while (roll(sender_idle_pct)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    range_low_i  <= lo;
    range_high_i <= hi;
    do @(posedge clk_i); while (in_stall_o);
    predict_draw(op, lo, hi, produces, d);
    if (produces)
      pending_draws.push_back(known ? typed : d);
    requests_sent++;
  endtask

  function automatic logic [31:0] pick_edge();
    case ($urandom_range(4))
      0: return Q_MIN;
      1: return Q_MAX;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return 32'h0000_0001;
    endcase
  endfunction

  task automatic send_random();
    int          pick;
    logic [1:0]  op;
    logic [31:0] lo;
    logic [31:0] hi;
    pick = $urandom_range(99);
    lo = $urandom;
    hi = $urandom;
    if (pick < 30)      op = xss_pkg::OP_FRACTION;
    else if (pick < 55) op = xss_pkg::OP_COIN;
    else if (pick < 93) op = xss_pkg::OP_RANGE;
    else                op = xss_pkg::OP_NONE;
    if (op == xss_pkg::OP_RANGE) begin
      case ($urandom_range(9))
        0: hi = lo;
        1: begin
          lo = pick_edge();
          hi = pick_edge();
        end
        2, 3: hi = lo + $urandom_range(1, 15);
        default: ;
      endcase
    end
    send_request(op, lo, hi, 1'b0, '0);
  endtask

  // Dropped requests give no result, so allow the unit to finish before a write.
  task automatic wait_drained();
    while (pending_draws.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_seed(input logic [63:0] value);
    in_valid_i <= 1'b0;
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    gen_state = (value == 64'd0) ? 64'd1 : value;
    seeds_loaded++;
  endtask

  always @(posedge clk_i) begin : draw_check
    draw_t want;
    draw_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{fraction_o, coin_o, range_value_o};
      draws_checked++;
      if (pending_draws.size() == 0) begin
        report_failure("unexpected transaction", '0, got);
      end else begin
        want = pending_draws.pop_front();
        if (got.frac !== want.frac)
          report_failure("fraction mismatch", want, got);
        else if (got.coin !== want.coin)
          report_failure("coin mismatch", want, got);
        else if (got.val !== want.val)
          report_failure("range_value mismatch", want, got);
      end
    end
    out_stall_i <= roll(stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_draws.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : run
    logic [63:0] phase_seed;
    gen_state = 64'd1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pass on the reset seed with no idling.
    for (int r = 0; r < NUM_ROWS; r++)
      send_request(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].lo, DIRECTED_ROWS[r].hi,
                   DIRECTED_ROWS[r].known, DIRECTED_ROWS[r].typed);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: phase_seed = 64'd0;
        1: phase_seed = 64'hFFFF_FFFF_FFFF_FFFF;
        2: phase_seed = 64'd1;
        3: phase_seed = 64'h8000_0000_0000_0000;
        default: phase_seed = {$urandom, $urandom};
      endcase
      load_seed(phase_seed);
      case (p % 4)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 55; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 55; end
        default: begin sender_idle_pct = 19; stall_pct = 19; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_random();
    end

    in_valid_i <= 1'b0;
    wait_drained();
    if (pending_draws.size() != 0) begin
      failures++;
      $display("%0d expected results never arrived", pending_draws.size());
    end

    $display("covered %0d requests (%0d directed) and %0d results over %0d seed loads",
             requests_sent, NUM_ROWS, draws_checked, seeds_loaded);
    $display("idle patterns: none, sender gaps, receiver stalls, both; %0d failures",
             failures);
    if (failures == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- xorshift_star_random_source_unit.f -----
hdl/xss_pkg.sv
hdl/xss_mul.sv
hdl/xorshift_star_random_source_unit.sv
dv/xorshift_star_random_source_unit_test.sv
